// ===== hdl/iff_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared request, result and job types, conversion codes and constants.
// ----------------------------------------------------------------------------
package iff_pkg;

  localparam int unsigned MaxFieldDefault  = 64;
  localparam int unsigned DigitDepthDefault = 22;

  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_OCT  = 3'd2,
    OP_HEXL = 3'd3,
    OP_HEXU = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    LEN_INT   = 2'd0,
    LEN_SHORT = 2'd1,
    LEN_LONG  = 2'd2
  } len_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] value_bits;
    logic [1:0]  length_mode;
    logic [6:0]  field_width;
    logic [5:0]  digit_precision;
    logic        has_precision;
    logic        left_justify;
    logic        force_plus;
    logic        space_sign;
    logic        alternate_form;
    logic        zero_pad;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } res_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [63:0] mag;
    logic [1:0]  radix_sel;   // 0 dec, 1 oct, 2 hex
    logic        upper;
    logic [7:0]  sign_char;
    logic        has_sign;
    logic        alt;
    logic [6:0]  field_width;
    logic [5:0]  prec;
    logic        has_precision;
    logic        left_justify;
    logic        zero_pad;
  } job_t;

  localparam logic [1:0] RadixDec = 2'd0;
  localparam logic [1:0] RadixOct = 2'd1;
  localparam logic [1:0] RadixHex = 2'd2;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else if (upper) c = 8'h41 + {4'd0, d} - 8'd10;
    else c = 8'h61 + {4'd0, d} - 8'd10;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/iff_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iff_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 22
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/iff_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer field formatter front end
// Accept requests, cut and sign the value, pick the radix and the sign.
// ----------------------------------------------------------------------------
module iff_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire iff_pkg::req_t req_i,
  output logic               job_valid_o,
  input  wire logic          job_stall_i,
  output iff_pkg::job_t      job_o
);
  iff_pkg::job_t job_d;
  iff_pkg::job_t job_q [2];
  logic [1:0]    cnt_q;
  logic          wr_q, rd_q;
  logic          push, pop;
  logic [63:0]   v;
  logic          neg;
  logic [2:0]    op;

  assign req_stall_o = (cnt_q == 2'd2);
  assign push = req_valid_i && !req_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop = job_valid_o && !job_stall_i;
  assign job_o = job_q[rd_q];

  always_comb begin
    op = (req_i.operation > iff_pkg::OP_HEXU) ? iff_pkg::OP_UDEC : req_i.operation;
    case (req_i.length_mode)
      iff_pkg::LEN_SHORT: v = {48'd0, req_i.value_bits[15:0]};
      iff_pkg::LEN_INT:   v = {32'd0, req_i.value_bits[31:0]};
      default:            v = req_i.value_bits;
    endcase
    neg = 1'b0;
    if (op == iff_pkg::OP_SDEC) begin
      case (req_i.length_mode)
        iff_pkg::LEN_SHORT: neg = v[15];
        iff_pkg::LEN_INT:   neg = v[31];
        default:            neg = v[63];
      endcase
    end
    job_d = '0;
    if (neg) begin
      case (req_i.length_mode)
        iff_pkg::LEN_SHORT: job_d.mag = {48'd0, 16'(-v[15:0])};
        iff_pkg::LEN_INT:   job_d.mag = {32'd0, 32'(-v[31:0])};
        default:            job_d.mag = -v;
      endcase
    end else begin
      job_d.mag = v;
    end
    case (op)
      iff_pkg::OP_OCT:                   job_d.radix_sel = iff_pkg::RadixOct;
      iff_pkg::OP_HEXL, iff_pkg::OP_HEXU: job_d.radix_sel = iff_pkg::RadixHex;
      default:                           job_d.radix_sel = iff_pkg::RadixDec;
    endcase
    job_d.upper = (op == iff_pkg::OP_HEXU);
    job_d.has_sign = 1'b0;
    job_d.sign_char = 8'h20;
    if (op == iff_pkg::OP_SDEC) begin
      if (neg) begin
        job_d.has_sign = 1'b1; job_d.sign_char = 8'h2d;
      end else if (req_i.force_plus) begin
        job_d.has_sign = 1'b1; job_d.sign_char = 8'h2b;
      end else if (req_i.space_sign) begin
        job_d.has_sign = 1'b1;
      end
    end
    job_d.alt = req_i.alternate_form;
    job_d.field_width = req_i.field_width;
    job_d.prec = req_i.has_precision ? req_i.digit_precision : 6'd1;
    job_d.has_precision = req_i.has_precision;
    job_d.left_justify = req_i.left_justify;
    job_d.zero_pad = req_i.zero_pad;
  end

  always_ff @(posedge clk_i) begin
    if (push) job_q[wr_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0; wr_q <= 1'b0; rd_q <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/iff_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer field formatter back end
// Extract digits into the digit RAM (octal and hex digits directly, decimal
// digits in four 16-bit chunks each), then emit the field.
// ----------------------------------------------------------------------------
module iff_back #(
  parameter int unsigned MaxField   = iff_pkg::MaxFieldDefault,
  parameter int unsigned DigitDepth = iff_pkg::DigitDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  output logic               job_stall_o,
  input  wire iff_pkg::job_t job_i,
  output logic               res_valid_o,
  input  wire logic          res_stall_i,
  output iff_pkg::res_t      res_o
);
  localparam int unsigned AW = $clog2(DigitDepth);
  localparam int unsigned CW = $clog2(DigitDepth + 1);
  localparam logic [19:0] DecRecip = 20'd838861;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_PLAN  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_WAIT  = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    P_LPAD, P_SIGN, P_PFX0, P_PFXX, P_ZPAD, P_ZERO, P_DIG, P_RPAD
  } part_e;

  state_e        state_q, state_d;
  iff_pkg::job_t job_q;
  logic [63:0]   mag_q;
  logic [CW-1:0] cnt_q;
  logic [6:0]    zeros_q, pad_q, run_q, pos_q;
  logic [1:0]    pfx_q;
  part_e         part_q;
  logic [CW-1:0] didx_q;
  logic          out_v_q, rd_pend_q;
  iff_pkg::res_t out_q;
  logic [1:0]    sub_q;
  logic [3:0]    drem_q;

  // digit step: divide by radix, decimal in four 16-bit chunks
  logic [63:0] quo;
  logic [3:0]  rem;
  logic [19:0] dec_x;
  logic [39:0] dec_prod;
  logic [15:0] dec_q;
  logic [19:0] dec_r;
  always_comb begin
    dec_x = {(sub_q == 2'd0) ? 4'd0 : drem_q, mag_q[63:48]};
    dec_prod = dec_x * DecRecip;
    dec_q = dec_prod[38:23];
    dec_r = dec_x - dec_q * 20'd10;
    case (job_q.radix_sel)
      iff_pkg::RadixOct: begin quo = mag_q >> 3; rem = {1'b0, mag_q[2:0]}; end
      iff_pkg::RadixHex: begin quo = mag_q >> 4; rem = mag_q[3:0]; end
      default: begin
        quo = {mag_q[47:0], dec_q};
        rem = dec_r[3:0];
      end
    endcase
  end

  logic we, is_dec, go, dec_run;
  logic [7:0] rdata;
  logic [AW-1:0] raddr;
  assign is_dec = (job_q.radix_sel != iff_pkg::RadixOct) &&
                  (job_q.radix_sel != iff_pkg::RadixHex);
  assign go = (mag_q != 64'd0) && (cnt_q < CW'(DigitDepth));
  assign dec_run = (state_q == S_DIV) && is_dec && (sub_q != 2'd0 || go);
  assign we = (state_q == S_DIV) && (is_dec ? (sub_q == 2'd3) : go);
  assign raddr = AW'(didx_q - CW'(1));

  iff_ram #(.Width(8), .Depth(DigitDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (iff_pkg::digit_char(rem, job_q.upper)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // plan lengths
  logic [6:0] zeros_c, body_c;
  logic [1:0] pfx_c;
  always_comb begin
    zeros_c = (7'(job_q.prec) > 7'(cnt_q)) ? 7'(job_q.prec) - 7'(cnt_q) : 7'd0;
    pfx_c = 2'd0;
    if (job_q.alt) begin
      if (job_q.radix_sel == iff_pkg::RadixOct && zeros_c == 7'd0) pfx_c = 2'd1;
      else if (job_q.radix_sel == iff_pkg::RadixHex && cnt_q != '0) pfx_c = 2'd2;
    end
    body_c = 7'(job_q.has_sign) + 7'(pfx_c) + zeros_c + 7'(cnt_q);
  end

  logic zfill;
  assign zfill = !job_q.left_justify && job_q.zero_pad && !job_q.has_precision;

  // sequencing of emitted parts
  logic out_free, emit_now, fin, rem_done;
  logic [7:0] ch;
  part_e part_n;
  logic skip;
  assign out_free = !out_v_q || !res_stall_i;
  assign res_valid_o = out_v_q;
  assign res_o = out_q;
  assign job_stall_o = (state_q != S_IDLE);

  always_comb begin
    ch = 8'h20; skip = 1'b0;
    case (part_q)
      P_LPAD: begin skip = job_q.left_justify || zfill || run_q == 0; ch = 8'h20; end
      P_SIGN: begin skip = !job_q.has_sign; ch = job_q.sign_char; end
      P_PFX0: begin skip = pfx_q == 2'd0; ch = 8'h30; end
      P_PFXX: begin skip = pfx_q != 2'd2; ch = job_q.upper ? 8'h58 : 8'h78; end
      P_ZPAD: begin skip = !zfill || run_q == 0; ch = 8'h30; end
      P_ZERO: begin skip = run_q == 0; ch = 8'h30; end
      P_DIG:  begin skip = didx_q == '0; ch = rdata; end
      P_RPAD: begin skip = !job_q.left_justify || run_q == 0; ch = 8'h20; end
      default: skip = 1'b1;
    endcase
  end

  // run counter for the part that follows
  function automatic logic [6:0] run_for(input part_e p, input logic [6:0] pad,
                                         input logic [6:0] z);
    logic [6:0] r;
    case (p)
      P_ZPAD, P_RPAD: r = pad;
      P_ZERO: r = z;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    part_n = part_e'(3'(part_q) + 3'd1);
  end

  assign emit_now = (state_q == S_EMIT) && !skip && !rd_pend_q && out_free;
  // part finishes after this char or skip
  always_comb begin
    rem_done = 1'b1;
    case (part_q)
      P_LPAD, P_ZPAD, P_ZERO, P_RPAD: rem_done = (run_q <= 7'd1);
      P_DIG: rem_done = (didx_q <= CW'(1));
      default: rem_done = 1'b1;
    endcase
  end
  // last: position limit or final nonempty char
  logic rest_empty;
  always_comb begin
    rest_empty = 1'b1;
    if (part_q < P_PFXX && pfx_q == 2'd2) rest_empty = 1'b0;
    if (part_q < P_PFX0 && pfx_q != 2'd0) rest_empty = 1'b0;
    if (part_q < P_ZPAD && zfill && pad_q != 0) rest_empty = 1'b0;
    if (part_q < P_ZERO && zeros_q != 0) rest_empty = 1'b0;
    if (part_q < P_DIG && cnt_q != '0) rest_empty = 1'b0;
    if (part_q < P_RPAD && job_q.left_justify && pad_q != 0) rest_empty = 1'b0;
    if (part_q < P_SIGN && job_q.has_sign) rest_empty = 1'b0;
  end
  assign fin = rem_done && (rest_empty || part_q == P_RPAD);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (job_valid_i) state_d = S_DIV;
      S_DIV:  if (!go && (!is_dec || sub_q == 2'd0)) state_d = S_PLAN;
      S_PLAN: state_d = (7'(body_c) == 7'd0 && job_q.field_width == 7'd0) ? S_IDLE : S_EMIT;
      S_EMIT: if (emit_now && (fin || pos_q == 7'(MaxField - 1))) state_d = S_WAIT;
              else if (skip && part_q == P_RPAD) state_d = S_WAIT;
      S_WAIT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (job_valid_i) begin job_q <= job_i; mag_q <= job_i.mag; end
      S_DIV: begin
        if (dec_run || we) mag_q <= quo;
        if (dec_run) drem_q <= dec_r[3:0];
      end
      S_PLAN: begin
        zeros_q <= zeros_c;
        pfx_q <= pfx_c;
        pad_q <= (job_q.field_width > body_c) ? job_q.field_width - body_c : 7'd0;
        run_q <= (job_q.field_width > body_c) ? job_q.field_width - body_c : 7'd0;
        part_q <= P_LPAD;
        didx_q <= cnt_q;
      end
      S_EMIT: begin
        if (emit_now) begin
          out_q.char_out <= ch;
          out_q.last_char <= fin || pos_q == 7'(MaxField - 1);
        end
        if ((emit_now && rem_done) || (skip && !rd_pend_q)) begin
          part_q <= part_n;
          run_q <= run_for(part_n, pad_q, zeros_q);
        end else if (emit_now) begin
          run_q <= run_q - 7'd1;
          if (part_q == P_DIG) didx_q <= didx_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; pos_q <= 7'd0;
      out_v_q <= 1'b0; rd_pend_q <= 1'b0; sub_q <= 2'd0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) cnt_q <= '0;
      else if (we) cnt_q <= cnt_q + CW'(1);
      if (state_q == S_IDLE) sub_q <= 2'd0;
      else if (dec_run) sub_q <= sub_q + 2'd1;
      if (state_q == S_PLAN) pos_q <= 7'd0;
      else if (emit_now) pos_q <= pos_q + 7'd1;
      if (emit_now) out_v_q <= 1'b1;
      else if (!res_stall_i) out_v_q <= 1'b0;
      // Registered RAM read: wait for read data on entry to digits and after each digit
      rd_pend_q <= (state_q == S_EMIT) &&
                   ((part_n == P_DIG && ((emit_now && rem_done) || (skip && !rd_pend_q)))
                   || (part_q == P_DIG && emit_now && !rem_done));
    end
  end
endmodule
`default_nettype wire

// ===== hdl/integer_field_formatter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer field formatter core
// One request in, its printf-style characters out one at a time, held while
// the output stalls. A request passes the front end and enters the back
// end, then the divide-by-radix step extracts each octal or hex digit (up to
// 22) or each decimal digit (up to 20, in four 16-bit chunks) plus one
// closing check; a planning step follows, then each emitted character (up to
// MaxField) with a bubble ahead of each digit read from the digit RAM, a
// step for each empty part of the field and one closing step. A two-entry
// queue holds classified requests between front and back.
// ----------------------------------------------------------------------------
module integer_field_formatter_core #(
  parameter int unsigned MaxField   = iff_pkg::MaxFieldDefault,
  parameter int unsigned DigitDepth = iff_pkg::DigitDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire iff_pkg::req_t req_i,
  output logic               res_valid_o,
  input  wire logic          res_stall_i,
  output iff_pkg::res_t      res_o
);
  logic          job_valid, job_stall;
  iff_pkg::job_t job;

  iff_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .job_valid_o (job_valid), .job_stall_i (job_stall), .job_o (job)
  );

  iff_back #(.MaxField(MaxField), .DigitDepth(DigitDepth)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid), .job_stall_o (job_stall), .job_i (job),
    .res_valid_o, .res_stall_i, .res_o
  );
endmodule
`default_nettype wire
